FILE: hdl/yle_pkg.sv
package yle_pkg;

  localparam logic [7:0] CodePlain = 8'd42;
  localparam logic [7:0] CodeEsc   = 8'd106;
  localparam logic [7:0] LineReset = 8'd128;

  localparam logic [7:0] ChEsc   = 8'h3D;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } yle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } yle_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       esc;
    logic [7:0] data;
    logic       nl;
  } yle_cmd_t;

endpackage

FILE: hdl/yle_front.sv
module yle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        line_length_i,
  input  logic              in_valid_i,
  input  yle_pkg::yle_in_t  in_req_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output yle_pkg::yle_cmd_t cmd_o
);
  import yle_pkg::*;

  logic [8:0] col_q, col_d;
  logic [7:0] coded;
  logic       always_crit, edge_crit, at_edge, esc;
  logic [9:0] col_next;
  logic       nl;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    coded       = in_req_i.in_byte + CodePlain;
    always_crit = (coded == ChNul) || (coded == ChNl) || (coded == ChCr) || (coded == ChEsc);
    edge_crit   = (coded == ChTab) || (coded == ChSpace) || (coded == ChDot);
    at_edge     = (col_q == 9'd0) || ({1'b0, col_q} + 10'd1 >= {2'b00, line_length_i});
    esc         = always_crit || (edge_crit && at_edge);
    col_next    = {1'b0, col_q} + 10'd1 + {9'd0, esc};
    nl          = in_req_i.stream_end || (col_next >= {2'b00, line_length_i});
    col_d       = nl ? 9'd0 : col_next[8:0];

    cmd_o.esc  = esc;
    cmd_o.data = esc ? (in_req_i.in_byte + CodeEsc) : coded;
    cmd_o.nl   = nl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
    end
  end

  // column never passes one beyond the longest line
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= 9'd256)
    else $error("column out of range");

endmodule

FILE: hdl/yle_queue.sv
module yle_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  yle_pkg::yle_cmd_t data_i,
  input  logic              pop_i,
  output yle_pkg::yle_cmd_t data_o,
  output logic              full_o,
  output logic              empty_o
);
  import yle_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  yle_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

FILE: hdl/yle_back.sv
module yle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  yle_pkg::yle_cmd_t cmd_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output yle_pkg::yle_out_t out_req_o
);
  import yle_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  yle_out_t   out_q, beat;
  logic       load, emit, last_beat;
  logic [1:0] beat_last_idx;

  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && !q_empty_i;

  always_comb begin
    beat_last_idx = {1'b0, cmd_i.esc} + {1'b0, cmd_i.nl};
    last_beat     = (phase_q == beat_last_idx);
    if (cmd_i.esc && phase_q == 2'd0) begin
      beat.out_byte = ChEsc;
      beat.run_last = 1'b0;
    end else if (phase_q == {1'b0, cmd_i.esc}) begin
      beat.out_byte = cmd_i.data;
      beat.run_last = !cmd_i.nl;
    end else begin
      beat.out_byte = ChNl;
      beat.run_last = 1'b1;
    end
    pop_o       = emit && last_beat;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      phase_d     = last_beat ? 2'd0 : phase_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("phase out of range");

  // a request half sent must still sit at the queue head
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd0 |-> !q_empty_i)
    else $error("request lost mid-run");

endmodule

FILE: hdl/yenc_line_encoder.sv
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_req_i  (in_byte, stream_end)
// out     | out_valid_o| out_stall_i | out_req_o (out_byte, run_last)
// cfg     | cfg_we_i   | -           | cfg_wdata_i (line_length)
//
// One byte accepted per cycle while the queue is not full; the back end
// sends one result per cycle while out_stall_i is low, so a byte with an
// escape or a newline gives 2 or 3 results. The first result passes through
// the queue and then the output register before it is offered.
// Input stalls only when the request queue is full.
// Reset clears column, queue and output valid; line_length returns to 128.
module yenc_line_encoder #(
  parameter int QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  yle_pkg::yle_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output yle_pkg::yle_out_t out_req_o
);
  import yle_pkg::*;

  logic [7:0] line_length_q;
  logic       push, pop, q_full, q_empty;
  yle_cmd_t   cmd_in, cmd_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LineReset;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  yle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_length_i (line_length_q),
    .in_valid_i    (in_valid_i),
    .in_req_i      (in_req_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  yle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  yle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
